// File: rtl/core/sine_pwm_inverse_park_clarke_core_assert.svh
// Assertion macros for the sine PWM commutation core.
// Expects clk and rst_n in the scope of each use.
`ifndef SINE_PWM_INVERSE_PARK_CLARKE_CORE_ASSERT_SVH
`define SINE_PWM_INVERSE_PARK_CLARKE_CORE_ASSERT_SVH
// same-cycle implication
`define SPIC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SPIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/core/spic_pkg.sv
// Shared constants, sine table and stage payload types of the sine PWM core.
// No dependencies.
`default_nettype none
package spic_pkg;
  localparam int SINE_DEPTH = 200;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam logic [7:0] SUPPLY_LIMIT_RST = 8'd24;
  localparam logic [32:0] ANGLE_BIAS = 33'd2147818400;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [18:0] HALF_PI_Q16 = 19'd102944;
  localparam logic [18:0] PI_Q16 = 19'd205888;
  localparam logic [18:0] THREE_HALF_PI_Q16 = 19'd308832;
  localparam logic [25:0] MOD_RECIP = 26'd42722812;
  localparam logic [22:0] INDEX_SCALE_Q16 = 23'd8302579;
  localparam logic signed [11:0] FOLD1 = 12'(2 * SINE_DEPTH - 2);
  localparam logic signed [11:0] FOLD2 = 12'(4 * SINE_DEPTH - 4);
  localparam logic [18:0] DIV625_RECIP = 19'd429497;
  localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
  localparam int DIV_BITS = 8;

  localparam logic [13:0] SINE_TBL [SINE_DEPTH] = '{
    14'd0, 14'd79, 14'd158, 14'd237, 14'd316, 14'd395, 14'd473, 14'd552, 14'd631, 14'd710,
    14'd789, 14'd867, 14'd946, 14'd1024, 14'd1103, 14'd1181, 14'd1260, 14'd1338, 14'd1416,
    14'd1494, 14'd1572, 14'd1650, 14'd1728, 14'd1806, 14'd1883, 14'd1961, 14'd2038, 14'd2115,
    14'd2192, 14'd2269, 14'd2346, 14'd2423, 14'd2499, 14'd2575, 14'd2652, 14'd2728, 14'd2804,
    14'd2879, 14'd2955, 14'd3030, 14'd3105, 14'd3180, 14'd3255, 14'd3329, 14'd3404, 14'd3478,
    14'd3552, 14'd3625, 14'd3699, 14'd3772, 14'd3845, 14'd3918, 14'd3990, 14'd4063, 14'd4135,
    14'd4206, 14'd4278, 14'd4349, 14'd4420, 14'd4491, 14'd4561, 14'd4631, 14'd4701, 14'd4770,
    14'd4840, 14'd4909, 14'd4977, 14'd5046, 14'd5113, 14'd5181, 14'd5249, 14'd5316, 14'd5382,
    14'd5449, 14'd5515, 14'd5580, 14'd5646, 14'd5711, 14'd5775, 14'd5839, 14'd5903, 14'd5967,
    14'd6030, 14'd6093, 14'd6155, 14'd6217, 14'd6279, 14'd6340, 14'd6401, 14'd6461, 14'd6521,
    14'd6581, 14'd6640, 14'd6699, 14'd6758, 14'd6815, 14'd6873, 14'd6930, 14'd6987, 14'd7043,
    14'd7099, 14'd7154, 14'd7209, 14'd7264, 14'd7318, 14'd7371, 14'd7424, 14'd7477, 14'd7529,
    14'd7581, 14'd7632, 14'd7683, 14'd7733, 14'd7783, 14'd7832, 14'd7881, 14'd7930, 14'd7977,
    14'd8025, 14'd8072, 14'd8118, 14'd8164, 14'd8209, 14'd8254, 14'd8298, 14'd8342, 14'd8385,
    14'd8428, 14'd8470, 14'd8512, 14'd8553, 14'd8594, 14'd8634, 14'd8673, 14'd8712, 14'd8751,
    14'd8789, 14'd8826, 14'd8863, 14'd8899, 14'd8935, 14'd8970, 14'd9005, 14'd9039, 14'd9072,
    14'd9105, 14'd9138, 14'd9169, 14'd9201, 14'd9231, 14'd9261, 14'd9291, 14'd9320, 14'd9348,
    14'd9376, 14'd9403, 14'd9429, 14'd9455, 14'd9481, 14'd9506, 14'd9530, 14'd9554, 14'd9577,
    14'd9599, 14'd9621, 14'd9642, 14'd9663, 14'd9683, 14'd9702, 14'd9721, 14'd9739, 14'd9757,
    14'd9774, 14'd9790, 14'd9806, 14'd9821, 14'd9836, 14'd9850, 14'd9863, 14'd9876, 14'd9888,
    14'd9899, 14'd9910, 14'd9920, 14'd9930, 14'd9939, 14'd9947, 14'd9955, 14'd9962, 14'd9969,
    14'd9975, 14'd9980, 14'd9985, 14'd9989, 14'd9992, 14'd9995, 14'd9997, 14'd9999, 14'd10000,
    14'd10000
  };

  typedef struct packed {
    logic signed [14:0] sin_v;
    logic signed [14:0] cos_v;
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
  } trig_t;

  typedef struct packed {
    logic [23:0] ph_a;
    logic [23:0] ph_b;
    logic [23:0] ph_c;
  } phase_t;
endpackage
`default_nettype wire

// File: rtl/core/sine_pwm_inverse_park_clarke_core.sv
// Sine PWM commutation core: turns a q/d voltage pair and an electrical angle into three
// 8-bit phase compare values. One item per clock is taken when the output side keeps up;
// each item passes 19 register stages (5 stages angle reduction and sine/cosine lookup,
// 5 stages inverse Park/Clarke and clamp, 9 stages duty scaling and division by the supply
// limit, one quotient bit per stage after the scaling stage). Any stage that holds a bubble
// takes a new item even while the result waits.
// supply_limit (reset 24) is written through the cfg channel, which is always ready;
// write it only while no item is in flight.
// Depends on spic_pkg, spic_trig, spic_park and spic_duty.
`default_nettype none
module sine_pwm_inverse_park_clarke_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_volt_q,
  input  wire logic signed [15:0] in_volt_d,
  input  wire logic signed [31:0] in_elec_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_duty_a,
  output logic [7:0]              out_duty_b,
  output logic [7:0]              out_duty_c,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_supply_limit
);
  import spic_pkg::*;

  logic [7:0] lim_r;
  trig_t  trig;
  phase_t phase;
  logic trig_valid, trig_ready, ph_valid, ph_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= SUPPLY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      lim_r <= cfg_supply_limit;
    end
  end

  spic_trig u_trig (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_volt_q(in_volt_q), .in_volt_d(in_volt_d), .in_elec_angle(in_elec_angle),
    .out_valid(trig_valid), .out_ready(trig_ready), .out_trig(trig)
  );

  spic_park u_park (
    .clk(clk), .rst_n(rst_n), .lim(lim_r),
    .in_valid(trig_valid), .in_ready(trig_ready), .in_trig(trig),
    .out_valid(ph_valid), .out_ready(ph_ready), .out_phase(phase)
  );

  spic_duty u_duty (
    .clk(clk), .rst_n(rst_n), .lim(lim_r),
    .in_valid(ph_valid), .in_ready(ph_ready), .in_phase(phase),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_duty_a(out_duty_a), .out_duty_b(out_duty_b), .out_duty_c(out_duty_c)
  );
endmodule
`default_nettype wire

// File: rtl/core/spic_trig.sv
// Angle reduction, table index and quarter-wave sine/cosine lookup, five stages.
// Depends on spic_pkg.
`default_nettype none
module spic_trig (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_volt_q,
  input  wire logic signed [15:0] in_volt_d,
  input  wire logic signed [31:0] in_elec_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spic_pkg::trig_t         out_trig
);
  import spic_pkg::*;

  localparam int NST = 5;
  localparam logic [1:0] QUAD_I = 2'd0;
  localparam logic [1:0] QUAD_II = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV = 2'd3;

  function automatic logic [1:0] quad_of(input logic [18:0] a);
    logic [1:0] q;
    if (a < HALF_PI_Q16) q = QUAD_I;
    else if (a < PI_Q16) q = QUAD_II;
    else if (a < THREE_HALF_PI_Q16) q = QUAD_III;
    else q = QUAD_IV;
    return q;
  endfunction

  function automatic logic signed [14:0] fold_lookup(input logic [9:0] idx,
                                                    input logic [1:0] quad);
    logic signed [11:0] i;
    logic signed [11:0] f;
    logic [SINE_IDX_W-1:0] k;
    logic signed [14:0] mag;
    i = signed'({2'b00, idx});
    case (quad)
      QUAD_I:   f = i;
      QUAD_II:  f = FOLD1 - i;
      QUAD_III: f = i - FOLD1;
      default:  f = FOLD2 - i;
    endcase
    if (f < 0) k = '0;
    else if (f > signed'(12'(SINE_DEPTH - 1))) k = SINE_IDX_W'(SINE_DEPTH - 1);
    else k = f[SINE_IDX_W-1:0];
    mag = signed'({1'b0, SINE_TBL[k]});
    return quad[1] ? -mag : mag;
  endfunction

  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  logic [15:0] vq_r [NST];
  logic [15:0] vd_r [NST];

  logic [32:0] u_r;
  logic [46:0] p_r;
  logic [19:0] r_r;
  logic [18:0] a_r, b_r;
  logic [9:0]  idx_s_r, idx_c_r;
  logic [1:0]  quad_s_r, quad_c_r;
  logic signed [14:0] sin_r, cos_r;

  logic [32:0] u_nxt;
  logic [46:0] p_nxt;
  logic [32:0] diff;
  logic [18:0] a_nxt;
  logic [19:0] b_sum;
  logic [18:0] b_nxt;
  logic [41:0] pa, pb;

  always_comb begin
    en[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) en[i] = !vld_r[i] || en[i+1];
  end
  assign in_ready = en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (en[i]) vld_r[i] <= vld_r[i-1];
    end
  end

  always_comb begin
    u_nxt = {in_elec_angle[31], in_elec_angle} + ANGLE_BIAS;
    p_nxt = 47'(u_nxt[32:12]) * 47'(MOD_RECIP);
    diff  = u_r - 33'(p_r[45:32]) * 33'(TWO_PI_Q16);
    a_nxt = (r_r >= 20'(TWO_PI_Q16)) ? 19'(r_r - 20'(TWO_PI_Q16)) : r_r[18:0];
    b_sum = 20'(a_nxt) + 20'(HALF_PI_Q16);
    b_nxt = (b_sum >= 20'(TWO_PI_Q16)) ? 19'(b_sum - 20'(TWO_PI_Q16)) : b_sum[18:0];
    pa = 42'(a_r) * 42'(INDEX_SCALE_Q16) + 42'h0_8000_0000;
    pb = 42'(b_r) * 42'(INDEX_SCALE_Q16) + 42'h0_8000_0000;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r <= u_nxt;
      p_r <= p_nxt;
      vq_r[0] <= in_volt_q;
      vd_r[0] <= in_volt_d;
    end
    if (en[1]) r_r <= diff[19:0];
    if (en[2]) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
    if (en[3]) begin
      idx_s_r  <= pa[41:32];
      idx_c_r  <= pb[41:32];
      quad_s_r <= quad_of(a_r);
      quad_c_r <= quad_of(b_r);
    end
    if (en[4]) begin
      sin_r <= fold_lookup(idx_s_r, quad_s_r);
      cos_r <= fold_lookup(idx_c_r, quad_c_r);
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        vq_r[i] <= vq_r[i-1];
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  assign out_trig.sin_v  = sin_r;
  assign out_trig.cos_v  = cos_r;
  assign out_trig.volt_q = signed'(vq_r[NST-1]);
  assign out_trig.volt_d = signed'(vd_r[NST-1]);
endmodule
`default_nettype wire

// File: rtl/core/spic_park.sv
// Inverse Park to whole volts, inverse Clarke around the center and clamp, five stages.
// Depends on spic_pkg.
`default_nettype none
module spic_park (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] lim,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  spic_pkg::trig_t in_trig,
  output logic            out_valid,
  input  wire logic       out_ready,
  output spic_pkg::phase_t out_phase
);
  import spic_pkg::*;

  localparam int NST = 5;

  function automatic logic [23:0] clamp_ph(input logic signed [27:0] u,
                                           input logic [23:0] top);
    logic [23:0] r;
    if (u < 0) r = '0;
    else if (u > signed'({4'b0000, top})) r = top;
    else r = u[23:0];
    return r;
  endfunction

  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  logic signed [30:0] pcd_r, psq_r, psd_r, pcq_r;
  logic [17:0] xa_r, xb_r;
  logic        na_r, nb_r;
  logic signed [9:0] alpha2_r, beta2_r, alpha3_r;
  logic signed [27:0] bprod_r;
  phase_t ph_r;

  logic signed [31:0] num_a, num_b;
  logic [31:0] abs_a, abs_b;
  logic [36:0] qa_p, qb_p;
  logic signed [9:0] alpha_nxt, beta_nxt;
  logic signed [27:0] a28, cen, ua, ub, uc;
  logic [23:0] top;

  always_comb begin
    en[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) en[i] = !vld_r[i] || en[i+1];
  end
  assign in_ready = en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (en[i]) vld_r[i] <= vld_r[i-1];
    end
  end

  always_comb begin
    num_a = 32'(pcd_r) - 32'(psq_r);
    num_b = 32'(psd_r) + 32'(pcq_r);
    abs_a = num_a[31] ? 32'(-num_a) : 32'(num_a);
    abs_b = num_b[31] ? 32'(-num_b) : 32'(num_b);
    qa_p = 37'(xa_r) * 37'(DIV625_RECIP);
    qb_p = 37'(xb_r) * 37'(DIV625_RECIP);
    alpha_nxt = na_r ? -signed'({1'b0, qa_p[36:28]}) : signed'({1'b0, qa_p[36:28]});
    beta_nxt  = nb_r ? -signed'({1'b0, qb_p[36:28]}) : signed'({1'b0, qb_p[36:28]});
    a28 = 28'(alpha3_r);
    cen = signed'({5'b00000, lim[7:1], 16'h0000});
    top = {lim, 16'h0000};
    ua = (a28 <<< 16) + cen;
    ub = -(a28 <<< 15) + bprod_r + cen;
    uc = -(a28 <<< 15) - bprod_r + cen;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pcd_r <= 31'(in_trig.cos_v) * 31'(in_trig.volt_d);
      psq_r <= 31'(in_trig.sin_v) * 31'(in_trig.volt_q);
      psd_r <= 31'(in_trig.sin_v) * 31'(in_trig.volt_d);
      pcq_r <= 31'(in_trig.cos_v) * 31'(in_trig.volt_q);
    end
    if (en[1]) begin
      xa_r <= abs_a[29:12];
      xb_r <= abs_b[29:12];
      na_r <= num_a[31];
      nb_r <= num_b[31];
    end
    if (en[2]) begin
      alpha2_r <= alpha_nxt;
      beta2_r  <= beta_nxt;
    end
    if (en[3]) begin
      alpha3_r <= alpha2_r;
      bprod_r  <= 28'(beta2_r) * 28'(signed'({1'b0, SQRT3_HALF_Q16}));
    end
    if (en[4]) begin
      ph_r.ph_a <= clamp_ph(ua, top);
      ph_r.ph_b <= clamp_ph(ub, top);
      ph_r.ph_c <= clamp_ph(uc, top);
    end
  end

  assign out_phase = ph_r;
endmodule
`default_nettype wire

// File: rtl/core/spic_duty.sv
// Duty scaling: phase times 255 over the limit, by a one-bit-per-stage divider.
// Depends on spic_pkg.
`default_nettype none
module spic_duty (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  lim,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  spic_pkg::phase_t in_phase,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_duty_a,
  output logic [7:0]       out_duty_b,
  output logic [7:0]       out_duty_c
);
  import spic_pkg::*;

  localparam int NST = DIV_BITS + 1;

  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  logic [15:0] rem_r [NST][3];
  logic [7:0]  quo_r [NST][3];
  logic [15:0] rem_nxt [NST][3];
  logic [7:0]  quo_nxt [NST][3];
  logic [23:0] ph [3];
  logic [31:0] scaled [3];
  logic [15:0] trial;

  always_comb begin
    en[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) en[i] = !vld_r[i] || en[i+1];
  end
  assign in_ready = en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (en[i]) vld_r[i] <= vld_r[i-1];
    end
  end

  always_comb begin
    ph[0] = in_phase.ph_a;
    ph[1] = in_phase.ph_b;
    ph[2] = in_phase.ph_c;
    trial = '0;
    for (int l = 0; l < 3; l++) begin
      scaled[l] = {ph[l], 8'h00} - {8'h00, ph[l]};
      rem_nxt[0][l] = scaled[l][31:16];
      quo_nxt[0][l] = '0;
    end
    for (int j = 1; j < NST; j++) begin
      trial = 16'({8'h00, lim} << (DIV_BITS - j));
      for (int l = 0; l < 3; l++) begin
        if (rem_r[j-1][l] >= trial) begin
          rem_nxt[j][l] = rem_r[j-1][l] - trial;
          quo_nxt[j][l] = quo_r[j-1][l] | 8'(1 << (DIV_BITS - j));
        end else begin
          rem_nxt[j][l] = rem_r[j-1][l];
          quo_nxt[j][l] = quo_r[j-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NST; j++) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
      end
    end
  end

  assign out_duty_a = (lim == 8'd0) ? 8'd0 : quo_r[NST-1][0];
  assign out_duty_b = (lim == 8'd0) ? 8'd0 : quo_r[NST-1][1];
  assign out_duty_c = (lim == 8'd0) ? 8'd0 : quo_r[NST-1][2];
endmodule
`default_nettype wire

// File: rtl/core/spic_checker.sv
// Port-level checks of the sine PWM core, bound to the top level.
// Depends on sine_pwm_inverse_park_clarke_core_assert.svh.
`default_nettype none
`include "sine_pwm_inverse_park_clarke_core_assert.svh"
module spic_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_duty_a,
  input wire logic [7:0] out_duty_b,
  input wire logic [7:0] out_duty_c,
  input wire logic       cfg_ready
);
  logic [23:0] duty_all;

  assign duty_all = {out_duty_a, out_duty_b, out_duty_c};

  `SPIC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty_all), "stalled item changed")
  `SPIC_ASSERT_IMPL(a_full_stall, !in_ready, out_valid && !out_ready, "input blocked without output stall")
  `SPIC_ASSERT_IMPL(a_fill_free, !out_valid, in_ready, "pipeline blocked while output empty")
  `SPIC_ASSERT_IMPL(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")
endmodule

bind sine_pwm_inverse_park_clarke_core spic_checker u_spic_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_duty_a(out_duty_a),
  .out_duty_b(out_duty_b), .out_duty_c(out_duty_c), .cfg_ready(cfg_ready)
);
`default_nettype wire
